>>> rtl/frp_pkg.sv
// Shared types, codes and constants of the FASTA record parser.
package frp_pkg;

	// Character table reach; codes at or above it are never sequence text
	localparam int unsigned CHAR_TABLE_SIZE = 128;

	localparam logic [7:0] MARKER_CHAR  = 8'h3E;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

	// Result queue depth; must be a power of two and at least 4
	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_HDR  = 3'd0,
		KIND_SEQ  = 3'd1,
		KIND_DONE = 3'd2,
		KIND_END  = 3'd3,
		KIND_ERR  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_MARKER   = 3'd1,
		ERR_HDR_LONG = 3'd2,
		ERR_SEQ_LONG = 3'd3,
		ERR_BAD_CHAR = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		REG_ALLOWED_LO = 3'd0,
		REG_ALLOWED_HI = 3'd1,
		REG_IGNORED_LO = 3'd2,
		REG_IGNORED_HI = 3'd3,
		REG_MAX_HDR    = 3'd4,
		REG_MAX_SEQ    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [31:0] record_length;
		err_t        error_code;
		logic        last;
	} res_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] b, logic [31:0] len, err_t e);
		res_t r;
		r.kind          = k;
		r.out_byte      = b;
		r.record_length = len;
		r.error_code    = e;
		r.last          = 1'b0;
		return r;
	endfunction

endpackage

>>> rtl/fasta_record_parser.sv
// Top level of the FASTA record parser: input stage, parse logic and settings.
//
// Input stream s_*: one byte per transfer in s_tdata; s_tlast high marks the
// end of the stream (the byte is then disregarded). Output stream m_*: one
// result per transfer, kind on m_tuser, m_tlast on the final result of an
// input transfer. Settings are written through cfg_wen/cfg_index/cfg_data
// while the stream is idle; unknown indexes are dropped.
// An accepted byte is registered in the input stage; the parse logic then
// writes its results into the result queue, whose head drives m_*.
// Throughput: one byte per cycle while the queue has room; an end of stream
// inside an open record yields two results. Rate is set by the
// single parse stage, which advances whenever the four-entry result queue
// has room for two results.
// A receiver stall fills the queue, then holds the parse stage, then drops
// s_tready; nothing is lost. Reset clears the parse state, the sticky error
// and the queue and restores the default settings (newline ignored, no
// allowed characters, limits at maximum).
module fasta_record_parser import frp_pkg::*; #(
	parameter int HEADER_COUNT_WIDTH = 16,
	parameter int SEQ_COUNT_WIDTH    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [7:0] out_byte, [39:8] record_length, [42:40] error_code
	output logic [2:0]  m_tuser,  // [2:0] kind
	output logic        m_tlast,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int HW = HEADER_COUNT_WIDTH;
	localparam int SW = SEQ_COUNT_WIDTH;
	localparam int HCMP_W = (HW > 16) ? HW : 16;
	localparam int SCMP_W = (SW > 32) ? SW : 32;

	typedef enum logic [1:0] {
		PH_MARKER = 2'd0,
		PH_HEADER = 2'd1,
		PH_SEQ    = 2'd2,
		PH_ERROR  = 2'd3
	} phase_t;

	// Settings
	logic [127:0] allowed_q;
	logic [127:0] ignored_q;
	logic [15:0]  max_hdr_q;
	logic [31:0]  max_seq_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	// Parse state
	phase_t        phase_q, phase_d;
	logic [HW-1:0] hcnt_q, hcnt_d;
	logic [SW-1:0] scnt_q, scnt_d;
	logic          line_q, line_d;
	err_t          err_q, err_d;

	res_t        r0, r1, dout;
	logic [1:0]  n_res;
	logic        q_room;
	logic        advance;
	logic        bad_byte;
	logic        hdr_full;
	logic        seq_full;
	logic [SCMP_W-1:0] scnt_ext;
	logic [31:0]  cur_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_q <= '0;
			ignored_q <= 128'd1024;
			max_hdr_q <= 16'hFFFF;
			max_seq_q <= 32'hFFFF_FFFF;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_ALLOWED_LO: allowed_q[63:0]   <= cfg_data;
				REG_ALLOWED_HI: allowed_q[127:64] <= cfg_data;
				REG_IGNORED_LO: ignored_q[63:0]   <= cfg_data;
				REG_IGNORED_HI: ignored_q[127:64] <= cfg_data;
				REG_MAX_HDR:    max_hdr_q         <= cfg_data[15:0];
				REG_MAX_SEQ:    max_seq_q         <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && q_room;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	assign bad_byte = byte_s1[7] || ({1'b0, byte_s1} >= 9'(CHAR_TABLE_SIZE));
	assign hdr_full = (HCMP_W'(hcnt_q) >= HCMP_W'(max_hdr_q)) || (&hcnt_q);
	assign seq_full = (SCMP_W'(scnt_q) >= SCMP_W'(max_seq_q)) || (&scnt_q);
	assign scnt_ext = SCMP_W'(scnt_q);
	assign cur_len  = scnt_ext[31:0];

	always_comb begin
		phase_d = phase_q;
		hcnt_d  = hcnt_q;
		scnt_d  = scnt_q;
		line_d  = line_q;
		err_d   = err_q;
		r0      = mk_res(KIND_ERR, 8'd0, 32'd0, err_q);
		r1      = mk_res(KIND_END, 8'd0, 32'd0, ERR_NONE);
		n_res   = 2'd0;
		if (phase_q == PH_ERROR) begin
			n_res = 2'd1;
		end else if (eoi_s1) begin
			// close an open record first, then report the end
			if (phase_q == PH_MARKER) begin
				r0    = mk_res(KIND_END, 8'd0, 32'd0, ERR_NONE);
				n_res = 2'd1;
			end else begin
				r0    = mk_res(KIND_DONE, 8'd0,
					(phase_q == PH_SEQ) ? cur_len : 32'd0, ERR_NONE);
				n_res = 2'd2;
			end
			phase_d = PH_MARKER;
			hcnt_d  = '0;
			scnt_d  = '0;
			line_d  = 1'b1;
		end else begin
			unique case (phase_q)
				PH_MARKER: begin
					if (byte_s1 != MARKER_CHAR) begin
						phase_d = PH_ERROR;
						err_d   = ERR_MARKER;
						r0      = mk_res(KIND_ERR, 8'd0, 32'd0, ERR_MARKER);
						n_res   = 2'd1;
					end else begin
						phase_d = PH_HEADER;
						hcnt_d  = '0;
						scnt_d  = '0;
						line_d  = 1'b1;
					end
				end
				PH_HEADER: begin
					if (byte_s1 == NEWLINE_CHAR) begin
						phase_d = PH_SEQ;
						scnt_d  = '0;
						line_d  = 1'b1;
					end else if (hdr_full) begin
						phase_d = PH_ERROR;
						err_d   = ERR_HDR_LONG;
						r0      = mk_res(KIND_ERR, 8'd0, 32'd0, ERR_HDR_LONG);
						n_res   = 2'd1;
					end else begin
						hcnt_d = hcnt_q + HW'(1);
						r0     = mk_res(KIND_HDR, byte_s1, 32'd0, ERR_NONE);
						n_res  = 2'd1;
					end
				end
				default: begin
					if (line_q && byte_s1 == MARKER_CHAR) begin
						// marker at line start: close record, open next header
						r0      = mk_res(KIND_DONE, 8'd0, cur_len, ERR_NONE);
						n_res   = 2'd1;
						phase_d = PH_HEADER;
						hcnt_d  = '0;
						scnt_d  = '0;
						line_d  = 1'b1;
					end else begin
						line_d = (byte_s1 == NEWLINE_CHAR);
						if (bad_byte || (!ignored_q[byte_s1[6:0]] &&
							!allowed_q[byte_s1[6:0]])) begin
							phase_d = PH_ERROR;
							err_d   = ERR_BAD_CHAR;
							r0      = mk_res(KIND_ERR, 8'd0, 32'd0, ERR_BAD_CHAR);
							n_res   = 2'd1;
						end else if (ignored_q[byte_s1[6:0]]) begin
							n_res = 2'd0;
						end else if (seq_full) begin
							phase_d = PH_ERROR;
							err_d   = ERR_SEQ_LONG;
							r0      = mk_res(KIND_ERR, 8'd0, 32'd0, ERR_SEQ_LONG);
							n_res   = 2'd1;
						end else begin
							scnt_d = scnt_q + SW'(1);
							r0     = mk_res(KIND_SEQ, byte_s1, 32'd0, ERR_NONE);
							n_res  = 2'd1;
						end
					end
				end
			endcase
		end
		r0.last = (n_res == 2'd1);
		r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MARKER;
			hcnt_q  <= '0;
			scnt_q  <= '0;
			line_q  <= 1'b1;
			err_q   <= ERR_NONE;
		end else if (advance) begin
			phase_q <= phase_d;
			hcnt_q  <= hcnt_d;
			scnt_q  <= scnt_d;
			line_q  <= line_d;
			err_q   <= err_d;
		end
	end

	frp_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (advance && (n_res != 2'd0)),
		.push1  (advance && (n_res == 2'd2)),
		.din0   (r0),
		.din1   (r1),
		.room   (q_room),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.dout   (dout)
	);

	assign m_tdata = {5'd0, dout.error_code, dout.record_length, dout.out_byte};
	assign m_tuser = dout.kind;
	assign m_tlast = dout.last;

	// The error state always carries a real code
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |-> err_q != ERR_NONE)
		else $error("error phase without a stored code");

	// Error results leave with a non-zero code
	a_err_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_ERR |-> err_t'(m_tdata[42:40]) != ERR_NONE)
		else $error("error result with empty code");

	// Parse stage never runs into a queue short of two free entries
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> q_room)
		else $error("parse advanced without queue room");

	// Once in error, the phase stays there
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("error phase left before reset");

endmodule

>>> rtl/frp_outq.sv
// Small result queue taking up to two results per cycle and giving one.
module frp_outq import frp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push0,
	input  logic push1,
	input  res_t din0,
	input  res_t din1,
	output logic room,
	output logic valid,
	input  logic ready,
	output res_t dout
);

	res_t                mem [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic [OQ_CNT_W-1:0] n_push;
	logic                pop;

	assign valid  = (count_q != '0);
	assign pop    = valid && ready;
	assign dout   = mem[rd_ptr_q];
	assign room   = (count_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign n_push = OQ_CNT_W'(push0) + OQ_CNT_W'(push1);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem[wr_ptr_q] <= din0;
		end
		if (push1) begin
			mem[wr_ptr_q + OQ_PTR_W'(1)] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[OQ_PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			count_q <= count_q + n_push - OQ_CNT_W'(pop);
		end
	end

endmodule

>>> bench/fasta_record_parser_tb.sv
// Testbench of the FASTA record parser: directed and random byte streams against a predictor.
`timescale 1ns / 1ps

module fasta_record_parser_tb;
	import frp_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 200000;
	localparam int unsigned REPORT_LIMIT    = 10;
	localparam int unsigned RANDOM_PHASES   = 8;
	localparam int unsigned PHASE_ITEMS     = 140;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned HOLD_OFF_AFTER  = 300;
	localparam int unsigned IDLE_PERCENT    = 17;
	localparam logic [2:0]  CFG_IDX_SPARE   = 3'd6;

	typedef enum logic [1:0] {
		AWAIT_MARKER,
		IN_HEADER,
		IN_SEQUENCE,
		FAILED
	} parse_phase_t;

	// Predicts the results of every accepted byte and matches them against the output stream
	class record_parse_tracker;
		logic [63:0]  allowed_lo, allowed_hi, ignored_lo, ignored_hi;
		logic [15:0]  hdr_limit;
		logic [31:0]  seq_limit;
		parse_phase_t phase;
		logic [15:0]  hdr_count;
		logic [31:0]  seq_count;
		logic         line_start;
		err_t         sticky_err;
		res_t         pending_results[$];
		int unsigned  matched;
		int unsigned  errors;

		function new();
			allowed_lo = '0;
			allowed_hi = '0;
			ignored_lo = 64'd1 << NEWLINE_CHAR;
			ignored_hi = '0;
			hdr_limit  = '1;
			seq_limit  = '1;
			phase      = AWAIT_MARKER;
			hdr_count  = '0;
			seq_count  = '0;
			line_start = 1'b1;
			sticky_err = ERR_NONE;
			matched    = 0;
			errors     = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] v);
			case (idx)
			REG_ALLOWED_LO: allowed_lo = v;
			REG_ALLOWED_HI: allowed_hi = v;
			REG_IGNORED_LO: ignored_lo = v;
			REG_IGNORED_HI: ignored_hi = v;
			REG_MAX_HDR:    hdr_limit  = v[15:0];
			REG_MAX_SEQ:    seq_limit  = v[31:0];
			default: begin
			end
			endcase
		endfunction

		function bit in_map(logic [63:0] lo, logic [63:0] hi, logic [7:0] c);
			return c[6] ? hi[c[5:0]] : lo[c[5:0]];
		endfunction

		function bit ignores(logic [7:0] c);
			return in_map(ignored_lo, ignored_hi, c);
		endfunction

		// Allowed and not ignored: passed out and counted
		function bit counts(logic [7:0] c);
			return !ignores(c) && in_map(allowed_lo, allowed_hi, c);
		endfunction

		function void add_result(kind_t k, logic [7:0] b, logic [31:0] len, err_t e);
			res_t r;
			r.kind          = k;
			r.out_byte      = b;
			r.record_length = len;
			r.error_code    = e;
			r.last          = 1'b0;
			pending_results.push_back(r);
		endfunction

		function void fail(err_t e);
			phase      = FAILED;
			sticky_err = e;
			add_result(KIND_ERR, 8'd0, 32'd0, e);
		endfunction

		function void open_record();
			phase      = IN_HEADER;
			hdr_count  = '0;
			seq_count  = '0;
			line_start = 1'b1;
		endfunction

		function void take_byte(logic [7:0] b, logic eoi);
			int unsigned before_n;
			before_n = pending_results.size();
			if (phase == FAILED) begin
				add_result(KIND_ERR, 8'd0, 32'd0, sticky_err);
			end else if (eoi) begin
				if (phase != AWAIT_MARKER)
					add_result(KIND_DONE, 8'd0, (phase == IN_SEQUENCE) ? seq_count : 32'd0,
						ERR_NONE);
				add_result(KIND_END, 8'd0, 32'd0, ERR_NONE);
				phase      = AWAIT_MARKER;
				hdr_count  = '0;
				seq_count  = '0;
				line_start = 1'b1;
			end else if (phase == AWAIT_MARKER) begin
				if (b == MARKER_CHAR)
					open_record();
				else
					fail(ERR_MARKER);
			end else if (phase == IN_HEADER) begin
				if (b == NEWLINE_CHAR) begin
					phase      = IN_SEQUENCE;
					seq_count  = '0;
					line_start = 1'b1;
				end else if (hdr_count >= hdr_limit || hdr_count == '1) begin
					fail(ERR_HDR_LONG);
				end else begin
					hdr_count++;
					add_result(KIND_HDR, b, 32'd0, ERR_NONE);
				end
			end else if (line_start && b == MARKER_CHAR) begin
				// close the record, the marker opens the next header at once
				add_result(KIND_DONE, 8'd0, seq_count, ERR_NONE);
				open_record();
			end else begin
				line_start = (b == NEWLINE_CHAR);
				if (b[7] || b >= CHAR_TABLE_SIZE) begin
					fail(ERR_BAD_CHAR);
				end else if (!ignores(b)) begin
					if (!in_map(allowed_lo, allowed_hi, b))
						fail(ERR_BAD_CHAR);
					else if (seq_count >= seq_limit || seq_count == '1)
						fail(ERR_SEQ_LONG);
					else begin
						seq_count++;
						add_result(KIND_SEQ, b, 32'd0, ERR_NONE);
					end
				end
			end
			if (pending_results.size() > before_n)
				pending_results[pending_results.size() - 1].last = 1'b1;
		endfunction

		function void match_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result: kind %0d byte %h len %0d err %0d last %b",
						got.kind, got.out_byte, got.record_length, got.error_code, got.last);
				return;
			end
			want = pending_results.pop_front();
			matched++;
			if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
			    got.record_length !== want.record_length ||
			    got.error_code !== want.error_code || got.last !== want.last) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display({"result %0d mismatch (expected/actual): kind %0d/%0d byte %h/%h",
						" len %0d/%0d err %0d/%0d last %b/%b"}, matched,
						want.kind, got.kind, want.out_byte, got.out_byte,
						want.record_length, got.record_length,
						want.error_code, got.error_code, want.last, got.last);
			end
		endfunction

		function void report_leftovers();
			if (pending_results.size() != 0) begin
				$display("%0d expected results never arrived", pending_results.size());
				errors += pending_results.size();
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_wen;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	record_parse_tracker tracker = new();
	bit                  no_idle;
	int unsigned         items_sent;
	// sequence text that the current settings let through
	logic [7:0]          seq_chars[$];
	bit                  nl_ok;
	bit                  gt_ok;

	fasta_record_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_item(input logic [7:0] b, input logic eoi);
		while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eoi;
		do @(posedge clk); while (!s_tready);
		tracker.take_byte(b, eoi);
		items_sent++;
	endtask

	// Leaves cfg_wen high; the caller drops it after the last write
	task automatic write_setting(input logic [2:0] idx, input logic [63:0] v);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		tracker.write_reg(idx, v);
	endtask

	// Drain all results, then allow bytes that give no result to clear the pipe
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_map();
		case ($urandom_range(3))
		0: return '0;
		1: return '1;
		2: return {$urandom, $urandom};
		default: return {$urandom, $urandom} & {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [31:0] pick_limit(logic [31:0] top, int unsigned span);
		case ($urandom_range(3))
		0: return 32'd0;
		1: return top;
		default: return $urandom_range(span, 1);
		endcase
	endfunction

	// One well-formed record within the current limits, now and then cut by end of stream
	task automatic send_random_record();
		int unsigned hdr_len, slots, budget;
		logic [7:0]  c;
		bit          at_start, pick;
		if ($urandom_range(9) == 0)
			send_item(8'($urandom_range(255)), 1'b1);
		send_item(MARKER_CHAR, 1'b0);
		hdr_len = $urandom_range((tracker.hdr_limit > 10) ? 10 : tracker.hdr_limit);
		repeat (hdr_len) begin
			do c = 8'($urandom_range(255)); while (c == NEWLINE_CHAR);
			send_item(c, 1'b0);
		end
		if ($urandom_range(15) == 0) begin
			send_item(8'($urandom_range(255)), 1'b1);
			return;
		end
		send_item(NEWLINE_CHAR, 1'b0);
		budget   = (tracker.seq_limit > 1000) ? 1000 : tracker.seq_limit;
		at_start = 1'b1;
		slots    = $urandom_range(30);
		for (int i = 0; i < slots; i++) begin
			pick = 1'b1;
			if (nl_ok && $urandom_range(5) == 0)
				c = NEWLINE_CHAR;
			else if (!at_start && gt_ok && $urandom_range(19) == 0)
				c = MARKER_CHAR;
			else if (seq_chars.size() != 0)
				c = seq_chars[$urandom_range(seq_chars.size() - 1)];
			else
				pick = 1'b0;
			if (pick && tracker.counts(c)) begin
				if (budget == 0)
					pick = 1'b0;
				else
					budget--;
			end
			if (pick) begin
				send_item(c, 1'b0);
				at_start = (c == NEWLINE_CHAR);
			end
		end
		if (!at_start && nl_ok && !(tracker.counts(NEWLINE_CHAR) && budget == 0) &&
		    $urandom_range(3) != 0) begin
			send_item(NEWLINE_CHAR, 1'b0);
			at_start = 1'b1;
		end
		// a '>' mid-line would be read as sequence text, not as a new record, so close such a record by end of stream
		if (!at_start || $urandom_range(5) == 0)
			send_item(8'($urandom_range(255)), 1'b1);
	endtask

	// Output side: check every transfer, stall at random, hold off once for a long stretch
	initial begin
		int unsigned hold_left;
		bit          hold_done;
		res_t        got;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.kind          = kind_t'(m_tuser);
				got.out_byte      = m_tdata[7:0];
				got.record_length = m_tdata[39:8];
				got.error_code    = err_t'(m_tdata[42:40]);
				got.last          = m_tlast;
				tracker.match_result(got);
			end
			if (!hold_done && tracker.matched >= HOLD_OFF_AFTER && s_tvalid) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || $urandom_range(99) >= IDLE_PERCENT;
			end
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [7:0]  c;
		int unsigned start, limit;
		err_t        flaw;
		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tlast    <= 1'b0;
		cfg_wen    <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		no_idle    = 1'b0;
		items_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default settings: end of stream with no record, header extremes and '>' in header,
		// empty sequence closed by a marker, end of stream inside header and sequence
		send_item(8'h00, 1'b1);
		send_item(MARKER_CHAR, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(MARKER_CHAR, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(NEWLINE_CHAR, 1'b0);
		send_item(NEWLINE_CHAR, 1'b0);
		send_item(MARKER_CHAR, 1'b0);
		send_item("x", 1'b0);
		send_item(8'h5A, 1'b1);
		send_item(MARKER_CHAR, 1'b0);
		send_item(NEWLINE_CHAR, 1'b0);
		send_item(8'hA5, 1'b1);

		// Nucleotide tables: N and newline both allowed and ignored, space ignored,
		// header and sequence exactly at their limits, spare index dropped
		settle();
		write_setting(REG_ALLOWED_LO, 64'd1 << NEWLINE_CHAR);
		write_setting(REG_ALLOWED_HI, (64'd1 << 1) | (64'd1 << 3) | (64'd1 << 7) |
			(64'd1 << 14) | (64'd1 << 20));
		write_setting(REG_IGNORED_LO, (64'd1 << NEWLINE_CHAR) | (64'd1 << 32));
		write_setting(REG_IGNORED_HI, 64'd1 << 14);
		write_setting(REG_MAX_HDR, 64'd2);
		write_setting(REG_MAX_SEQ, 64'd3);
		write_setting(CFG_IDX_SPARE, '1);
		cfg_wen <= 1'b0;
		send_item(MARKER_CHAR, 1'b0);
		send_item("h", 1'b0);
		send_item("i", 1'b0);
		send_item(NEWLINE_CHAR, 1'b0);
		send_item("A", 1'b0);
		send_item("N", 1'b0);
		send_item(" ", 1'b0);
		send_item("C", 1'b0);
		send_item(NEWLINE_CHAR, 1'b0);
		send_item("G", 1'b0);
		send_item(NEWLINE_CHAR, 1'b0);
		send_item(MARKER_CHAR, 1'b0);
		send_item(8'h00, 1'b1);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			write_setting(REG_ALLOWED_LO, pick_map());
			write_setting(REG_ALLOWED_HI, pick_map());
			write_setting(REG_IGNORED_LO, pick_map() |
				(($urandom_range(3) != 0) ? (64'd1 << NEWLINE_CHAR) : 64'd0));
			write_setting(REG_IGNORED_HI, pick_map());
			write_setting(REG_MAX_HDR, 64'(pick_limit(32'h0000_FFFF, 16)));
			write_setting(REG_MAX_SEQ, 64'(pick_limit(32'hFFFF_FFFF, 40)));
			cfg_wen <= 1'b0;
			no_idle = (p == 3);
			seq_chars.delete();
			for (int code = 0; code < 128; code++)
				if (code != NEWLINE_CHAR && code != MARKER_CHAR &&
				    (tracker.ignores(8'(code)) || tracker.counts(8'(code))))
					seq_chars.push_back(8'(code));
			nl_ok = tracker.ignores(NEWLINE_CHAR) || tracker.counts(NEWLINE_CHAR);
			gt_ok = tracker.ignores(MARKER_CHAR) || tracker.counts(MARKER_CHAR);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS)
				send_random_record();
			send_item(8'($urandom_range(255)), 1'b1);
		end
		no_idle = 1'b0;

		// Errors stick until reset, so provoke exactly one kind, then check it repeats
		settle();
		flaw = err_t'($urandom_range(4, 1));
		case (flaw)
		ERR_MARKER: begin
			do c = 8'($urandom_range(255)); while (c == MARKER_CHAR);
			send_item(c, 1'b0);
		end
		ERR_HDR_LONG: begin
			limit = $urandom_range(4);
			write_setting(REG_MAX_HDR, 64'(limit));
			cfg_wen <= 1'b0;
			send_item(MARKER_CHAR, 1'b0);
			repeat (limit + 1) begin
				do c = 8'($urandom_range(255)); while (c == NEWLINE_CHAR);
				send_item(c, 1'b0);
			end
		end
		ERR_SEQ_LONG: begin
			limit = $urandom_range(4);
			write_setting(REG_ALLOWED_HI, 64'd1 << ("A" - 8'd64));
			write_setting(REG_IGNORED_HI, 64'd0);
			write_setting(REG_MAX_SEQ, 64'(limit));
			cfg_wen <= 1'b0;
			send_item(MARKER_CHAR, 1'b0);
			send_item(NEWLINE_CHAR, 1'b0);
			repeat (limit + 1)
				send_item("A", 1'b0);
		end
		default: begin
			write_setting(REG_ALLOWED_LO, 64'd0);
			write_setting(REG_ALLOWED_HI, 64'd0);
			write_setting(REG_IGNORED_LO, 64'd1 << NEWLINE_CHAR);
			write_setting(REG_IGNORED_HI, 64'd0);
			cfg_wen <= 1'b0;
			send_item(MARKER_CHAR, 1'b0);
			send_item(NEWLINE_CHAR, 1'b0);
			if ($urandom_range(1) == 0)
				c = 8'($urandom_range(255, 128));
			else
				do c = 8'($urandom_range(127));
				while (c == NEWLINE_CHAR || c == MARKER_CHAR);
			send_item(c, 1'b0);
		end
		endcase
		repeat (20)
			send_item(8'($urandom_range(255)), $urandom_range(3) == 0);

		settle();
		tracker.report_leftovers();
		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
